FILE: rtl/pf_pkg.sv
// Shared types, constants and the control store of the prime factorizer.
// Depends on nothing; pf_seq and prime_factorizer use it.
package pf_pkg;

  // Fixed widths of the result word, the cap on results per word and its counter width.
  localparam int PRIME_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FACTOR = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd2;

  // Step counter of the sequencer.
  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // Step addresses of the program.
  localparam upc_t S_IDLE     = 5'd0;
  localparam upc_t S_CHK_ZERO = 5'd1;
  localparam upc_t S_BAD      = 5'd2;
  localparam upc_t S_CHK_ONE  = 5'd3;
  localparam upc_t S_NONE     = 5'd4;
  localparam upc_t S_STRIP    = 5'd5;
  localparam upc_t S_HALVE    = 5'd6;
  localparam upc_t S_SQ_GO    = 5'd7;
  localparam upc_t S_SQ_WAIT  = 5'd8;
  localparam upc_t S_SQ_LOAD  = 5'd9;
  localparam upc_t S_LOOP     = 5'd10;
  localparam upc_t S_DIV_GO   = 5'd11;
  localparam upc_t S_DIV_WAIT = 5'd12;
  localparam upc_t S_REM_CHK  = 5'd13;
  localparam upc_t S_TAKE_Q   = 5'd14;
  localparam upc_t S_CAP_CHK  = 5'd15;
  localparam upc_t S_NEXT_D   = 5'd16;
  localparam upc_t S_TAIL     = 5'd17;
  localparam upc_t S_PUT_N    = 5'd18;
  localparam upc_t S_FIN      = 5'd19;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_EMIT_BAD,
    OP_EMIT_NONE,
    OP_HALVE_PUT2,
    OP_SQRT_START,
    OP_LOAD_ROOT,
    OP_DIV_START,
    OP_TAKE_Q_PUT_D,
    OP_D_ADD2,
    OP_PUT_N,
    OP_FLUSH
  } op_t;

  // Jump conditions; when the condition holds the step counter loads the target.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_N_NONZERO,
    C_N_NOT_ONE,
    C_ODD_OR_CAP,
    C_SQRT_BUSY,
    C_D_GT_ROOT_OR_CAP,
    C_DIV_BUSY,
    C_REM_NONZERO,
    C_NOT_CAP,
    C_N_LE2_OR_CAP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_word_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic start;
    logic n_zero;
    logic n_one;
    logic n_odd;
    logic n_le2;
    logic cap;
    logic sqrt_busy;
    logic div_busy;
    logic rem_zero;
    logic d_gt_root;
  } stat_t;

  // Control store: one word per step.
  function automatic ctrl_word_t ucode(input upc_t upc);
    ctrl_word_t cw;
    unique case (upc)
      S_IDLE:     cw = '{OP_NOP,          C_NO_START,         S_IDLE};
      S_CHK_ZERO: cw = '{OP_NOP,          C_N_NONZERO,        S_CHK_ONE};
      S_BAD:      cw = '{OP_EMIT_BAD,     C_ALWAYS,           S_IDLE};
      S_CHK_ONE:  cw = '{OP_NOP,          C_N_NOT_ONE,        S_STRIP};
      S_NONE:     cw = '{OP_EMIT_NONE,    C_ALWAYS,           S_IDLE};
      S_STRIP:    cw = '{OP_NOP,          C_ODD_OR_CAP,       S_SQ_GO};
      S_HALVE:    cw = '{OP_HALVE_PUT2,   C_ALWAYS,           S_STRIP};
      S_SQ_GO:    cw = '{OP_SQRT_START,   C_NEVER,            S_IDLE};
      S_SQ_WAIT:  cw = '{OP_NOP,          C_SQRT_BUSY,        S_SQ_WAIT};
      S_SQ_LOAD:  cw = '{OP_LOAD_ROOT,    C_NEVER,            S_IDLE};
      S_LOOP:     cw = '{OP_NOP,          C_D_GT_ROOT_OR_CAP, S_TAIL};
      S_DIV_GO:   cw = '{OP_DIV_START,    C_NEVER,            S_IDLE};
      S_DIV_WAIT: cw = '{OP_NOP,          C_DIV_BUSY,         S_DIV_WAIT};
      S_REM_CHK:  cw = '{OP_NOP,          C_REM_NONZERO,      S_NEXT_D};
      S_TAKE_Q:   cw = '{OP_TAKE_Q_PUT_D, C_NEVER,            S_IDLE};
      S_CAP_CHK:  cw = '{OP_NOP,          C_NOT_CAP,          S_DIV_GO};
      S_NEXT_D:   cw = '{OP_D_ADD2,       C_ALWAYS,           S_LOOP};
      S_TAIL:     cw = '{OP_NOP,          C_N_LE2_OR_CAP,     S_FIN};
      S_PUT_N:    cw = '{OP_PUT_N,        C_NEVER,            S_IDLE};
      S_FIN:      cw = '{OP_FLUSH,        C_ALWAYS,           S_IDLE};
      default:    cw = '{OP_NOP,          C_ALWAYS,           S_IDLE};
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/pf_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on nothing outside this file.
module pf_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         busy_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  // One shift-and-subtract step.
  always_comb begin
    shifted = {rem_r, quo_r[W-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_nxt = {quo_r[W-2:0], ge};
  end

  // Iteration control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(W);
      rem_r  <= '0;
      quo_r  <= dividend_i;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CW'(1);
    end
  end

  assign busy_o = busy_r;
  assign quot_o = quo_r;
  assign rem_o  = rem_r;

endmodule

FILE: rtl/pf_isqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on nothing outside this file.
module pf_isqrt #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [W-1:0]         radicand_i,
  output logic                 busy_o,
  output logic [(W+1)/2-1:0]   root_o
);

  localparam int RW = W + (W % 2);
  localparam int H  = RW / 2;
  localparam int CW = $clog2(H + 1);

  logic [RW-1:0] rad_r;
  logic [H+1:0]  rem_r, rem_nxt;
  logic [H-1:0]  root_r, root_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [H+1:0]  rem_sh;
  logic [H+1:0]  trial;
  logic          ge;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem_sh   = {rem_r[H-1:0], rad_r[RW-1:RW-2]};
    trial    = {root_r, 2'b01};
    ge       = rem_sh >= trial;
    rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[H-2:0], ge};
  end

  // Iteration control and working registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(H);
      rad_r  <= RW'(radicand_i);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CW'(1);
    end
  end

  assign busy_o = busy_r;
  assign root_o = root_r;

endmodule

FILE: rtl/pf_seq.sv
// Microcoded sequencer: step counter, control store lookup and jump logic.
// Depends on pf_pkg for the control word, flags and step addresses.
module pf_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  pf_pkg::stat_t stat_i,
  output pf_pkg::op_t   op_o,
  output logic          busy_o
);

  pf_pkg::upc_t       upc_r, upc_nxt;
  pf_pkg::ctrl_word_t cw;
  logic               take;

  // Decode the current word and pick the next step.
  always_comb begin
    cw = pf_pkg::ucode(upc_r);
    unique case (cw.cond)
      pf_pkg::C_NEVER:            take = 1'b0;
      pf_pkg::C_ALWAYS:           take = 1'b1;
      pf_pkg::C_NO_START:         take = !stat_i.start;
      pf_pkg::C_N_NONZERO:        take = !stat_i.n_zero;
      pf_pkg::C_N_NOT_ONE:        take = !stat_i.n_one;
      pf_pkg::C_ODD_OR_CAP:       take = stat_i.n_odd || stat_i.cap;
      pf_pkg::C_SQRT_BUSY:        take = stat_i.sqrt_busy;
      pf_pkg::C_D_GT_ROOT_OR_CAP: take = stat_i.d_gt_root || stat_i.cap;
      pf_pkg::C_DIV_BUSY:         take = stat_i.div_busy;
      pf_pkg::C_REM_NONZERO:      take = !stat_i.rem_zero;
      pf_pkg::C_NOT_CAP:          take = !stat_i.cap;
      pf_pkg::C_N_LE2_OR_CAP:     take = stat_i.n_le2 || stat_i.cap;
      default:                    take = 1'b1;
    endcase
    upc_nxt = take ? cw.target : upc_r + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= pf_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign op_o   = cw.op;
  assign busy_o = upc_r != pf_pkg::S_IDLE;

endmodule

FILE: rtl/prime_factorizer.sv
// Prime factorizer top level: trial-division datapath under a microcoded sequencer.
// Depends on pf_pkg, pf_seq, pf_div and pf_isqrt.
// Setup strips factors of two and takes the floor square root; then each odd trial divisor from 3
// up to that root is tried with the serial divider, and at 32 bits the worst case is about 32768
// trial divisors.
// One word at a time: busy drops in the cycle that carries the last result word.
// Synchronous reset returns the sequencer to idle and clears the strobe; no clearing pass.
module prime_factorizer #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [VALUE_WIDTH-1:0]      in_value,
  output logic                        out_valid,
  output logic [pf_pkg::PRIME_W-1:0]  out_prime,
  output logic                        out_last,
  output logic [pf_pkg::STATUS_W-1:0] out_status
);

  localparam int ROOT_W = (VALUE_WIDTH + 1) / 2;
  localparam int EXT_W  = (VALUE_WIDTH > pf_pkg::PRIME_W) ? VALUE_WIDTH : pf_pkg::PRIME_W;

  logic [VALUE_WIDTH-1:0]      n_r;
  logic [VALUE_WIDTH-1:0]      d_r;
  logic [ROOT_W-1:0]           root_r;
  logic [pf_pkg::CNT_W-1:0]    k_r;
  logic [pf_pkg::PRIME_W-1:0]  pend_r;
  logic                        pend_v_r;
  logic                        out_valid_r;
  logic [pf_pkg::PRIME_W-1:0]  out_prime_r;
  logic                        out_last_r;
  logic [pf_pkg::STATUS_W-1:0] out_status_r;

  pf_pkg::op_t                 op;
  pf_pkg::stat_t               stat;
  logic                        seq_busy;
  logic                        accept;
  logic                        div_busy;
  logic [VALUE_WIDTH-1:0]      div_quot;
  logic [VALUE_WIDTH-1:0]      div_rem;
  logic                        sqrt_busy;
  logic [ROOT_W-1:0]           sqrt_root;
  logic                        put_en;
  logic [pf_pkg::PRIME_W-1:0]  put_val;

  // Fit a working value to the prime field, dropping bits above it.
  function automatic logic [pf_pkg::PRIME_W-1:0] to_prime(input logic [VALUE_WIDTH-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[pf_pkg::PRIME_W-1:0];
  endfunction

  assign accept = start && !seq_busy;
  assign busy   = seq_busy;

  // Flags for the sequencer's jump conditions.
  always_comb begin
    stat.start     = accept;
    stat.n_zero    = n_r == '0;
    stat.n_one     = n_r == VALUE_WIDTH'(1);
    stat.n_odd     = n_r[0];
    stat.n_le2     = n_r <= VALUE_WIDTH'(2);
    stat.cap       = k_r == pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS);
    stat.sqrt_busy = sqrt_busy;
    stat.div_busy  = div_busy;
    stat.rem_zero  = div_rem == '0;
    stat.d_gt_root = d_r > VALUE_WIDTH'(root_r);
  end

  pf_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .stat_i (stat),
    .op_o   (op),
    .busy_o (seq_busy)
  );

  pf_div #(.W(VALUE_WIDTH)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (op == pf_pkg::OP_DIV_START),
    .dividend_i (n_r),
    .divisor_i  (d_r),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  pf_isqrt #(.W(VALUE_WIDTH)) u_isqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (op == pf_pkg::OP_SQRT_START),
    .radicand_i (n_r),
    .busy_o     (sqrt_busy),
    .root_o     (sqrt_root)
  );

  // Decode which operations hand a new factor to the pending slot.
  always_comb begin
    put_en  = 1'b0;
    put_val = '0;
    unique case (op)
      pf_pkg::OP_HALVE_PUT2: begin
        put_en  = 1'b1;
        put_val = pf_pkg::PRIME_W'(2);
      end
      pf_pkg::OP_TAKE_Q_PUT_D: begin
        put_en  = 1'b1;
        put_val = to_prime(d_r);
      end
      pf_pkg::OP_PUT_N: begin
        put_en  = 1'b1;
        put_val = to_prime(n_r);
      end
      default: begin
        put_en  = 1'b0;
      end
    endcase
  end

  // Datapath registers. A factor waits in the pending slot until the next one
  // arrives or the word finishes, so its last flag is known when it goes out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (accept) begin
        n_r      <= in_value;
        k_r      <= '0;
        pend_v_r <= 1'b0;
      end

      if (put_en) begin
        if (pend_v_r) begin
          out_valid_r  <= 1'b1;
          out_prime_r  <= pend_r;
          out_last_r   <= 1'b0;
          out_status_r <= pf_pkg::ST_FACTOR;
        end
        pend_r   <= put_val;
        pend_v_r <= 1'b1;
        k_r      <= k_r + 1'b1;
      end

      case (op)
        pf_pkg::OP_EMIT_BAD: begin
          out_valid_r  <= 1'b1;
          out_prime_r  <= '0;
          out_last_r   <= 1'b1;
          out_status_r <= pf_pkg::ST_BAD;
        end
        pf_pkg::OP_EMIT_NONE: begin
          out_valid_r  <= 1'b1;
          out_prime_r  <= '0;
          out_last_r   <= 1'b1;
          out_status_r <= pf_pkg::ST_NONE;
        end
        pf_pkg::OP_HALVE_PUT2: begin
          n_r <= n_r >> 1;
        end
        pf_pkg::OP_LOAD_ROOT: begin
          root_r <= sqrt_root;
          d_r    <= VALUE_WIDTH'(3);
        end
        pf_pkg::OP_TAKE_Q_PUT_D: begin
          n_r <= div_quot;
        end
        pf_pkg::OP_D_ADD2: begin
          d_r <= d_r + VALUE_WIDTH'(2);
        end
        pf_pkg::OP_FLUSH: begin
          if (pend_v_r) begin
            out_valid_r  <= 1'b1;
            out_prime_r  <= pend_r;
            out_last_r   <= 1'b1;
            out_status_r <= pf_pkg::ST_FACTOR;
          end
          pend_v_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_prime  = out_prime_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule
